// ===== rtl/dfiir_pkg.sv =====
// ----------------------------------------------------------------------------
// dfiir_pkg
// Types and fixed constants for the direct form I IIR filter core: register
// map, fixed-point widths and the output conversion limits.
// ----------------------------------------------------------------------------
package dfiir_pkg;

    // Register map, one 64-bit register every eight bytes.
    localparam int unsigned REG_COUNT        = 7;
    localparam int unsigned PADDR_W          = 6;
    localparam logic [2:0]  REG_NUM_TAPS     = 3'd0;
    localparam logic [2:0]  REG_DEN_TAPS     = 3'd1;
    localparam logic [2:0]  REG_NUM_PAIR_A   = 3'd2;
    localparam logic [2:0]  REG_NUM_PAIR_B   = 3'd3;
    localparam logic [2:0]  REG_NUM_LAST     = 3'd4;
    localparam logic [2:0]  REG_DEN_PAIR_A   = 3'd5;
    localparam logic [2:0]  REG_DEN_PAIR_B   = 3'd6;

    // Fixed-point widths.
    localparam int unsigned SAMPLE_W   = 12;
    localparam int unsigned X_W        = 13;
    localparam int unsigned Y_W        = 24;
    localparam int unsigned COEF_W     = 32;
    localparam int unsigned FRAC_Y     = 10;
    localparam int unsigned COEF_FRAC  = 27;
    localparam int unsigned OPND_W     = 24;
    localparam int unsigned PROD_W     = OPND_W + COEF_W;
    localparam int unsigned ACC_W      = 60;
    localparam int unsigned YQ_W       = ACC_W - COEF_FRAC;
    localparam int unsigned T_W        = 25;
    localparam int unsigned TERM_W     = 4;

    localparam logic signed [YQ_W-1:0] Y_MAX = YQ_W'(8388607);
    localparam logic signed [YQ_W-1:0] Y_MIN = -YQ_W'(8388608);

    // Mid-scale offset and top of the DAC range, in half-LSB units with
    // ten fraction bits.
    localparam logic signed [T_W-1:0] T_OFFSET = T_W'(4095 * 1024);
    localparam logic signed [T_W-1:0] T_TOP    = T_W'(8190 * 1024);

    localparam logic [SAMPLE_W-1:0] DAC_MAX = 12'd4095;

    typedef logic signed [X_W-1:0]    x_t;
    typedef logic signed [Y_W-1:0]    y_t;
    typedef logic signed [COEF_W-1:0] coef_t;

endpackage

// ===== rtl/direct_form_iir_filter_core.sv =====
// ----------------------------------------------------------------------------
// direct_form_iir_filter_core
// Direct form I IIR filter on a 12-bit converter stream, built around one
// shared 24x32 multiplier and accumulator.
// ----------------------------------------------------------------------------
// Each accepted sample word passes through the sequencer's MAC, SAT and OUT
// states, with one multiply for each of the nt + dt taps, where nt and dt are
// the feedforward and feedback tap counts in use. The single multiplier
// handles one tap per cycle, its product is registered and added into the
// accumulator on the following cycle, and once the last product is added the
// sequencer sees that nothing is left, saturates the sum in the SAT state and
// converts it to the DAC code in the OUT state. The input side is ready only
// while the sequencer is idle, which it reaches as the result is offered, so
// the block does not accept a new sample before it is through with the last
// one. A finished word waits in the output register while the next sample is
// processed; if it has still not been taken when the next result is done, the
// sequencer holds that result until the output register is free.
// Coefficients are signed Q4.27, the feedforward ones b0..b4 added into the
// sum and the feedback ones subtracted. Configuration is written through the
// APB port with 64-bit data at byte address 8*i; reset gives a pass-through
// filter.
// ----------------------------------------------------------------------------
module direct_form_iir_filter_core
    import dfiir_pkg::*;
#(
    parameter int unsigned MAX_NUM_TAPS = 5,
    parameter int unsigned MAX_DEN_TAPS = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [63:0]           pwdata,
    output logic [63:0]           prdata,
    output logic                  pready,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [SAMPLE_W-1:0]   s_sample,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [SAMPLE_W-1:0]   m_dac_code,
    output logic                  m_clipped
);

    localparam int unsigned HIST_D  = (MAX_DEN_TAPS > 0) ? MAX_DEN_TAPS : 1;
    localparam int unsigned NCOEF_N = 6;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MAC  = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    // Configuration registers.
    logic [2:0]  num_taps_reg;
    logic [2:0]  den_taps_reg;
    logic [63:0] num_pair_a_reg;
    logic [63:0] num_pair_b_reg;
    logic [31:0] num_last_reg;
    logic [63:0] den_pair_a_reg;
    logic [63:0] den_pair_b_reg;

    // Sequencer and datapath.
    logic [1:0]               state_reg;
    logic [TERM_W-1:0]        cnt_reg;
    logic [TERM_W-1:0]        total_reg;
    logic [TERM_W-1:0]        nt_reg;
    logic                     prod_valid_reg;
    logic                     prod_sub_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    y_t                       y_reg;
    x_t                       in_hist_reg  [MAX_NUM_TAPS];
    y_t                       out_hist_reg [HIST_D];

    logic                     m_valid_reg;
    logic [SAMPLE_W-1:0]      m_dac_code_reg;
    logic                     m_clipped_reg;

    logic                     cfg_wr;
    logic [2:0]               cfg_idx;
    logic [2:0]               nt;
    logic [2:0]               dt;
    x_t                       x_new;
    coef_t                    num_coef [NCOEF_N];
    coef_t                    den_coef [4];
    logic                     issue;
    logic                     is_num;
    logic [TERM_W-1:0]        den_idx;
    logic signed [OPND_W-1:0] opnd;
    coef_t                    coef;
    logic signed [YQ_W-1:0]   yq;
    y_t                       y_sat;
    logic signed [T_W-1:0]    t_val;
    logic                     out_load;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        case (cfg_idx)
            REG_NUM_TAPS:   prdata = {61'd0, num_taps_reg};
            REG_DEN_TAPS:   prdata = {61'd0, den_taps_reg};
            REG_NUM_PAIR_A: prdata = num_pair_a_reg;
            REG_NUM_PAIR_B: prdata = num_pair_b_reg;
            REG_NUM_LAST:   prdata = {32'd0, num_last_reg};
            REG_DEN_PAIR_A: prdata = den_pair_a_reg;
            REG_DEN_PAIR_B: prdata = den_pair_b_reg;
            default:        prdata = 64'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_taps_reg   <= 3'd1;
            den_taps_reg   <= 3'd0;
            num_pair_a_reg <= 64'h0000_0000_0800_0000;
            num_pair_b_reg <= 64'd0;
            num_last_reg   <= 32'd0;
            den_pair_a_reg <= 64'd0;
            den_pair_b_reg <= 64'd0;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_NUM_TAPS:   num_taps_reg   <= pwdata[2:0];
                REG_DEN_TAPS:   den_taps_reg   <= pwdata[2:0];
                REG_NUM_PAIR_A: num_pair_a_reg <= pwdata;
                REG_NUM_PAIR_B: num_pair_b_reg <= pwdata;
                REG_NUM_LAST:   num_last_reg   <= pwdata[31:0];
                REG_DEN_PAIR_A: den_pair_a_reg <= pwdata;
                REG_DEN_PAIR_B: den_pair_b_reg <= pwdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Operand and coefficient selection
    // ------------------------------------------------------------------
    assign nt = (num_taps_reg > 3'(MAX_NUM_TAPS)) ? 3'(MAX_NUM_TAPS) : num_taps_reg;
    assign dt = (den_taps_reg > 3'(MAX_DEN_TAPS)) ? 3'(MAX_DEN_TAPS) : den_taps_reg;

    // Offset-free sample in half-LSB units: 2*sample - 4095.
    assign x_new = {~s_sample[SAMPLE_W-1], s_sample[SAMPLE_W-2:0], 1'b1};

    // A sixth feedforward position has no register and reads as zero.
    assign num_coef[0] = num_pair_a_reg[31:0];
    assign num_coef[1] = num_pair_a_reg[63:32];
    assign num_coef[2] = num_pair_b_reg[31:0];
    assign num_coef[3] = num_pair_b_reg[63:32];
    assign num_coef[4] = num_last_reg;
    assign num_coef[5] = '0;
    assign den_coef[0] = den_pair_a_reg[31:0];
    assign den_coef[1] = den_pair_a_reg[63:32];
    assign den_coef[2] = den_pair_b_reg[31:0];
    assign den_coef[3] = den_pair_b_reg[63:32];

    assign issue   = (cnt_reg < total_reg);
    assign is_num  = (cnt_reg < nt_reg);
    assign den_idx = cnt_reg - nt_reg;

    always_comb begin
        opnd = '0;
        coef = '0;
        if (is_num) begin
            for (int i = 0; i < MAX_NUM_TAPS; i++) begin
                if (cnt_reg == TERM_W'(i)) begin
                    opnd = {{(OPND_W-X_W-FRAC_Y){in_hist_reg[i][X_W-1]}},
                            in_hist_reg[i], {FRAC_Y{1'b0}}};
                    coef = num_coef[i];
                end
            end
        end else begin
            for (int i = 0; i < MAX_DEN_TAPS; i++) begin
                if (den_idx == TERM_W'(i)) begin
                    opnd = out_hist_reg[i];
                    coef = den_coef[i];
                end
            end
        end
    end

    // Floor of the sum at the history's precision, then saturation.
    assign yq = acc_reg[ACC_W-1:COEF_FRAC];

    always_comb begin
        if (yq > Y_MAX) begin
            y_sat = Y_W'(Y_MAX);
        end else if (yq < Y_MIN) begin
            y_sat = Y_W'(Y_MIN);
        end else begin
            y_sat = yq[Y_W-1:0];
        end
    end

    assign t_val    = {y_reg[Y_W-1], y_reg} + T_OFFSET;
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    // ------------------------------------------------------------------
    // Sequencer, multiplier and accumulator
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            total_reg      <= '0;
            nt_reg         <= '0;
            prod_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_NUM_TAPS; i++) begin
                in_hist_reg[i] <= '0;
            end
            for (int i = 0; i < HIST_D; i++) begin
                out_hist_reg[i] <= '0;
            end
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        for (int i = MAX_NUM_TAPS - 1; i > 0; i--) begin
                            in_hist_reg[i] <= in_hist_reg[i-1];
                        end
                        in_hist_reg[0] <= x_new;
                        cnt_reg        <= '0;
                        nt_reg         <= TERM_W'(nt);
                        total_reg      <= TERM_W'(nt) + TERM_W'(dt);
                        prod_valid_reg <= 1'b0;
                        state_reg      <= ST_MAC;
                    end
                end
                ST_MAC: begin
                    prod_valid_reg <= issue;
                    if (issue) begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (!issue && !prod_valid_reg) begin
                        state_reg <= ST_SAT;
                    end
                end
                ST_SAT: begin
                    for (int i = HIST_D - 1; i > 0; i--) begin
                        out_hist_reg[i] <= out_hist_reg[i-1];
                    end
                    out_hist_reg[0] <= y_sat;
                    state_reg       <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Payload registers: the product is registered and summed in the following cycle.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE) begin
            acc_reg <= '0;
        end else if (state_reg == ST_MAC && prod_valid_reg) begin
            if (prod_sub_reg) begin
                acc_reg <= acc_reg - ACC_W'(prod_reg);
            end else begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
        prod_reg     <= opnd * coef;
        prod_sub_reg <= !is_num;
        if (state_reg == ST_SAT) begin
            y_reg <= y_sat;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            if (t_val < 0) begin
                m_dac_code_reg <= '0;
                m_clipped_reg  <= 1'b1;
            end else if (t_val > T_TOP) begin
                m_dac_code_reg <= DAC_MAX;
                m_clipped_reg  <= 1'b1;
            end else begin
                m_dac_code_reg <= t_val[FRAC_Y+SAMPLE_W:FRAC_Y+1];
                m_clipped_reg  <= 1'b0;
            end
        end
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign m_valid    = m_valid_reg;
    assign m_dac_code = m_dac_code_reg;
    assign m_clipped  = m_clipped_reg;

endmodule
